@@ rtl/sm3hs_pkg.sv @@
`default_nettype none

package sm3hs_pkg;

  localparam int unsigned WORDS   = 8;
  localparam int unsigned WIN_LEN = 16;

  localparam logic [31:0] T_LOW  = 32'h79cc4519;
  localparam logic [31:0] T_HIGH = 32'h7a879d8a;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam logic [31:0] SM3_IV [WORDS] = '{
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  // commands from the sequencer to the compression unit
  typedef struct packed {
    logic       shift_en;   // shift one byte into the message window
    logic [7:0] shift_byte;
    logic       start;      // begin 64 rounds on the current window
    logic       init_iv;    // reload the chaining value with the IV
  } sm3hs_cmd_t;

  function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
    rol32 = (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    perm0 = x ^ rol32(x, 9) ^ rol32(x, 17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    perm1 = x ^ rol32(x, 15) ^ rol32(x, 23);
  endfunction

endpackage

`default_nettype wire

@@ rtl/sm3hs_compress.sv @@
`default_nettype none

module sm3hs_compress (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire sm3hs_pkg::sm3hs_cmd_t   cmd,
  input  wire logic [2:0]              rd_idx,
  output logic [31:0]                  rd_word,
  output logic                         busy
);
  import sm3hs_pkg::*;

  logic [31:0] win_r  [WIN_LEN];
  logic [31:0] win_nxt[WIN_LEN];
  logic [31:0] st_r   [WORDS];
  logic [31:0] st_nxt [WORDS];
  logic [31:0] rnd_out[WORDS];
  logic [31:0] cv_r   [WORDS];
  logic [31:0] cv_nxt [WORDS];
  logic [31:0] tj_r, tj_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic        busy_r, busy_nxt;

  logic [31:0] w_new, a12, ss1, ss2, ff, gg, tt1, tt2;
  logic        early;

  assign busy    = busy_r;
  assign rd_word = cv_r[rd_idx];
  assign early   = (rnd_r[5:4] == 2'b00);

  // expansion: window holds W[j..j+15], this yields W[j+16]
  assign w_new = perm1(win_r[0] ^ win_r[7] ^ rol32(win_r[13], 15))
               ^ rol32(win_r[3], 7) ^ win_r[10];

  always_comb begin
    a12 = rol32(st_r[0], 12);
    ss1 = rol32(a12 + st_r[4] + tj_r, 7);
    ss2 = ss1 ^ a12;
    if (early) begin
      ff = st_r[0] ^ st_r[1] ^ st_r[2];
      gg = st_r[4] ^ st_r[5] ^ st_r[6];
    end else begin
      ff = (st_r[0] & st_r[1]) | (st_r[0] & st_r[2]) | (st_r[1] & st_r[2]);
      gg = (st_r[4] & st_r[5]) | (~st_r[4] & st_r[6]);
    end
    tt1 = ff + st_r[3] + ss2 + (win_r[0] ^ win_r[4]);
    tt2 = gg + st_r[7] + ss1 + win_r[0];
    rnd_out[0] = tt1;
    rnd_out[1] = st_r[0];
    rnd_out[2] = rol32(st_r[1], 9);
    rnd_out[3] = st_r[2];
    rnd_out[4] = perm0(tt2);
    rnd_out[5] = st_r[4];
    rnd_out[6] = rol32(st_r[5], 19);
    rnd_out[7] = st_r[6];
  end

  always_comb begin
    win_nxt = win_r;
    if (cmd.shift_en) begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        win_nxt[i] = {win_r[i][23:0], win_r[i+1][31:24]};
      end
      win_nxt[WIN_LEN-1] = {win_r[WIN_LEN-1][23:0], cmd.shift_byte};
    end else if (busy_r) begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        win_nxt[i] = win_r[i+1];
      end
      win_nxt[WIN_LEN-1] = w_new;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    cv_nxt   = cv_r;
    tj_nxt   = tj_r;
    rnd_nxt  = rnd_r;
    busy_nxt = busy_r;
    if (cmd.init_iv) begin
      cv_nxt = SM3_IV;
    end
    if (cmd.start) begin
      st_nxt   = cv_r;
      tj_nxt   = T_LOW;
      rnd_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      st_nxt  = rnd_out;
      // rotated round constant, T_HIGH takes over at round 16 pre-rotated
      tj_nxt  = (rnd_r == 6'd15) ? rol32(T_HIGH, 16) : rol32(tj_r, 1);
      rnd_nxt = rnd_r + 6'd1;
      if (rnd_r == 6'd63) begin
        busy_nxt = 1'b0;
        for (int i = 0; i < WORDS; i++) begin
          cv_nxt[i] = cv_r[i] ^ rnd_out[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    st_r  <= st_nxt;
    tj_r  <= tj_nxt;
    rnd_r <= rnd_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      cv_r   <= SM3_IV;
    end else begin
      busy_r <= busy_nxt;
      cv_r   <= cv_nxt;
    end
  end

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !busy_r)
    else $error("compression started while busy");

  a_no_shift_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !cmd.shift_en && !cmd.init_iv)
    else $error("window or chain touched during rounds");

  a_full_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> $past(rnd_r) == 6'd63)
    else $error("compression ended before round 63");

endmodule

`default_nettype wire

@@ rtl/sm3_hash_stream_top.sv @@
// Flow: a message or no-op beat is accepted in ST_IDLE; the 64th byte of a block
// also starts 64 rounds on the shared unit, with input held off until they end.
// The closing beat is followed by the padding bytes (0x80, zeros, length), one
// turn state before the length, one or two compressions, then eight digest
// beats one per cycle while out_tready holds, the first after the last rounds.
// Reset (rst_n low, synchronous): chaining value back to the IV, byte and
// length counters cleared, no pending results.
`default_nettype none

module sm3_hash_stream_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic [0:0]  in_tuser,   // [0] has_byte
  input  wire logic        in_tlast,   // last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] digest_word
  output logic [2:0]       out_tuser,  // [2:0] word_index
  output logic             out_tlast   // last_word
);
  import sm3hs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_COMP, ST_PAD80, ST_ZERO, ST_LEN, ST_OUT
  } state_t;

  state_t      state_r, state_nxt, ret_r, ret_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] msg_r, msg_nxt;
  logic [63:0] len_r, len_nxt;
  logic [2:0]  widx_r, widx_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [31:0] oword_r, oword_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  logic        olast_r, olast_nxt;

  sm3hs_cmd_t  cmd;
  logic [31:0] rd_word;
  logic        busy;
  logic        in_acc, out_acc;

  sm3hs_compress u_comp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd_idx  (widx_r),
    .rd_word (rd_word),
    .busy    (busy)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = ovalid_r && out_tready;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = oword_r;
  assign out_tuser  = oidx_r;
  assign out_tlast  = olast_r;

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    fill_nxt   = fill_r;
    msg_nxt    = msg_r;
    len_nxt    = len_r;
    widx_nxt   = widx_r;
    ovalid_nxt = ovalid_r;
    oword_nxt  = oword_r;
    oidx_nxt   = oidx_r;
    olast_nxt  = olast_r;
    cmd        = '0;
    if (out_acc) begin
      ovalid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0]) begin
            cmd.shift_en   = 1'b1;
            cmd.shift_byte = in_tdata;
            fill_nxt       = fill_r + 6'd1;
            msg_nxt        = msg_r + 64'd1;
            if (fill_r == 6'd63) begin
              cmd.start = 1'b1;
              state_nxt = ST_COMP;
              ret_nxt   = in_tlast ? ST_PAD80 : ST_IDLE;
            end else if (in_tlast) begin
              state_nxt = ST_PAD80;
            end
          end else if (in_tlast) begin
            state_nxt = ST_PAD80;
          end
        end
      end
      ST_COMP: begin
        if (!busy) begin
          state_nxt = ret_r;
        end
      end
      ST_PAD80: begin
        cmd.shift_en   = 1'b1;
        cmd.shift_byte = PAD_BYTE;
        fill_nxt       = fill_r + 6'd1;
        len_nxt        = {msg_r[60:0], 3'b000};
        if (fill_r == 6'd63) begin
          cmd.start = 1'b1;
          state_nxt = ST_COMP;
          ret_nxt   = ST_ZERO;
        end else begin
          state_nxt = ST_ZERO;
        end
      end
      ST_ZERO: begin
        // zeros up to the length field; past it, finish the block first
        if (fill_r == 6'd56) begin
          state_nxt = ST_LEN;
        end else begin
          cmd.shift_en   = 1'b1;
          cmd.shift_byte = 8'h00;
          fill_nxt       = fill_r + 6'd1;
          if (fill_r == 6'd63) begin
            cmd.start = 1'b1;
            state_nxt = ST_COMP;
            ret_nxt   = ST_ZERO;
          end
        end
      end
      ST_LEN: begin
        cmd.shift_en   = 1'b1;
        cmd.shift_byte = len_r[63:56];
        len_nxt        = {len_r[55:0], 8'h00};
        fill_nxt       = fill_r + 6'd1;
        if (fill_r == 6'd63) begin
          cmd.start = 1'b1;
          state_nxt = ST_COMP;
          ret_nxt   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          oword_nxt  = rd_word;
          oidx_nxt   = widx_r;
          olast_nxt  = (widx_r == 3'd7);
          widx_nxt   = widx_r + 3'd1;
          if (widx_r == 3'd7) begin
            cmd.init_iv = 1'b1;
            msg_nxt     = '0;
            state_nxt   = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    len_r   <= len_nxt;
    oword_r <= oword_nxt;
    oidx_r  <= oidx_nxt;
    olast_r <= olast_nxt;
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ret_r    <= ST_IDLE;
      fill_r   <= '0;
      msg_r    <= '0;
      widx_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      fill_r   <= fill_nxt;
      msg_r    <= msg_nxt;
      widx_r   <= widx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  a_len_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LEN) |-> fill_r[5:3] == 3'b111)
    else $error("length field not at the block tail");

  a_out_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_tlast && (state_r == ST_OUT) |=> ovalid_r)
    else $error("digest beats not back to back");

  a_digest_block_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> fill_r == 6'd0 && !busy)
    else $error("digest read with a partial block or running rounds");

endmodule

`default_nettype wire
